// ----- rtl/skss_pkg.sv -----
package skss_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_BITS = 7;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_EMIT   = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

endpackage

// ----- rtl/sorted_key_set_store.sv -----
// Sorted key store: keeps up to CAPACITY keys in ascending order in one
// single-port-read, single-port-write RAM.
// Input channel (i_in_valid / o_in_ready) carries a mode and a key; one item
// is in work at a time, and o_in_ready is high only while the block is idle.
// Output channel (o_out_valid / i_out_ready) carries key_out, status, last
// from an output register, so the next input can be taken while a result
// waits to be taken.
// Steps per item, from transfer in to the result loaded in the output register:
//   add    : walks down from the top entry, moving each key not below the new
//            key up by one, then writes the new key into the gap
//   remove : scans all entries upward, moving those after the match down by one
//   clear, add to a full store, remove or emit on an empty store : status only
//   emit   : keys from entry 0 upward, one key per cycle while the receiver
//            takes them
// The RAM read port walks one entry per cycle and its read data is registered.
// A stalled receiver holds the output register; emit then pauses on the
// current key and resumes when the transfer completes.
// Reset empties the store (count to zero) and drops any pending result; the
// RAM contents are not cleared and need no clearing pass.
module sorted_key_set_store
    import skss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_mode,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KEY_BITS-1:0] o_key_out,
    output logic [1:0]          o_status,
    output logic                o_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WALK,
        ST_ADD_PUT,
        ST_RM_SCAN,
        ST_EMIT,
        ST_RESP
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_found, n_found;
    logic [1:0]          r_resp, n_resp;
    logic                r_out_valid, n_out_valid;
    logic [KEY_BITS-1:0] r_key_out, n_key_out;
    logic [1:0]          r_status, n_status;
    logic                r_last, n_last;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_wr_addr;
    logic [KEY_BITS-1:0] mem_wr_data;
    logic [IDX_W-1:0]    mem_rd_addr;
    logic [KEY_BITS-1:0] mem_rd_data;

    logic             in_xfer;
    logic             out_free;
    logic [CNT_W-1:0] count_m1;
    logic             at_end;
    logic             hit;

    skss_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign count_m1    = r_count - CNT_W'(1);
    assign at_end      = ({{(CNT_W - IDX_W){1'b0}}, r_idx} == count_m1);
    assign hit         = (mem_rd_data == r_key);

    assign o_out_valid = r_out_valid;
    assign o_key_out   = r_key_out;
    assign o_status    = r_status;
    assign o_last      = r_last;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_found     = r_found;
        n_resp      = r_resp;
        n_out_valid = r_out_valid && !i_out_ready;
        n_key_out   = r_key_out;
        n_status    = r_status;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_wr_addr = r_idx;
        mem_wr_data = r_key;
        mem_rd_addr = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_key = i_key;
                    case (i_mode)
                        MODE_ADD: begin
                            n_idx = count_m1[IDX_W-1:0] + IDX_W'(1);
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_resp  = STAT_FULL;
                                n_state = ST_RESP;
                            end else if (r_count == '0) begin
                                n_idx   = '0;
                                n_state = ST_ADD_PUT;
                            end else begin
                                // fetch the top entry
                                mem_rd_addr = count_m1[IDX_W-1:0];
                                n_state     = ST_ADD_WALK;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_count == '0) begin
                                n_resp  = STAT_NOT_FOUND;
                                n_state = ST_RESP;
                            end else begin
                                mem_rd_addr = '0;
                                n_idx       = '0;
                                n_found     = 1'b0;
                                n_state     = ST_RM_SCAN;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                            n_resp  = STAT_OK;
                            n_state = ST_RESP;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_resp  = STAT_EMPTY;
                                n_state = ST_RESP;
                            end else begin
                                mem_rd_addr = '0;
                                n_idx       = '0;
                                n_state     = ST_EMIT;
                            end
                        end
                    endcase
                end
            end
            ST_ADD_WALK: begin
                // read data holds entry r_idx-1
                mem_we      = 1'b1;
                mem_wr_addr = r_idx;
                if (mem_rd_data >= r_key) begin
                    mem_wr_data = mem_rd_data;
                    n_idx       = r_idx - IDX_W'(1);
                    if (r_idx == IDX_W'(1)) begin
                        n_state = ST_ADD_PUT;
                    end else begin
                        mem_rd_addr = r_idx - IDX_W'(2);
                    end
                end else begin
                    mem_wr_data = r_key;
                    n_count     = r_count + CNT_W'(1);
                    n_resp      = STAT_OK;
                    n_state     = ST_RESP;
                end
            end
            ST_ADD_PUT: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_idx;
                mem_wr_data = r_key;
                n_count     = r_count + CNT_W'(1);
                n_resp      = STAT_OK;
                n_state     = ST_RESP;
            end
            ST_RM_SCAN: begin
                // read data holds entry r_idx; read ahead the next one
                mem_rd_addr = r_idx + IDX_W'(1);
                if (r_found) begin
                    // shift down over the removed entry
                    mem_we      = 1'b1;
                    mem_wr_addr = r_idx - IDX_W'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (at_end) begin
                    if (r_found || hit) begin
                        n_count = count_m1;
                        n_resp  = STAT_OK;
                    end else begin
                        n_resp  = STAT_NOT_FOUND;
                    end
                    n_state = ST_RESP;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_found = r_found || hit;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_key_out   = mem_rd_data;
                    n_status    = STAT_OK;
                    n_last      = at_end;
                    if (at_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx       = r_idx + IDX_W'(1);
                        mem_rd_addr = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_key_out   = '0;
                    n_status    = r_resp;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_found   <= n_found;
        r_resp    <= n_resp;
        r_key_out <= n_key_out;
        r_status  <= n_status;
        r_last    <= n_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_ADD_WALK || r_state == ST_ADD_PUT ||
                    r_state == ST_RM_SCAN))
        else $error("RAM write outside add or remove");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && at_end) |=> (r_state == ST_IDLE && o_last))
        else $error("emit did not finish on last key");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_mode == MODE_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the store");

    a_resp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && out_free) |=> (o_out_valid && o_last && o_key_out == '0))
        else $error("status result malformed");

endmodule

// ----- rtl/skss_ram.sv -----
module skss_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 7
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- verif/skss_checker.sv -----
`timescale 1ns / 100ps

module skss_checker
    import skss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [1:0]          i_mode,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [KEY_BITS-1:0] i_key_out,
    input  logic [1:0]          i_status,
    input  logic                i_last,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [KEY_BITS-1:0] key_out;
        logic [1:0]          status;
        logic                last;
    } t_store_result;

    t_store_result       expected_results [$];
    t_store_result       oldest_result;
    logic [KEY_BITS-1:0] sorted_keys [CAPACITY];
    int                  key_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        key_total    = 0;
    end

    // Append one result at the tail of the expected queue.
    function automatic void add_expected(input t_store_result result);
        expected_results = {expected_results, result};
    endfunction

    // Insertion sort: shift every stored key not below the new one up by one.
    function automatic logic [1:0] insert_key(input logic [KEY_BITS-1:0] key);
        int pos;
        if (key_total >= CAPACITY)
            return STAT_FULL;
        pos = key_total;
        while (pos > 0 && sorted_keys[pos-1] >= key) begin
            sorted_keys[pos] = sorted_keys[pos-1];
            pos--;
        end
        sorted_keys[pos] = key;
        key_total++;
        return STAT_OK;
    endfunction

    function automatic logic [1:0] remove_key(input logic [KEY_BITS-1:0] key);
        int hit_idx;
        hit_idx = -1;
        for (int i = 0; i < key_total; i++)
            if (hit_idx < 0 && sorted_keys[i] == key)
                hit_idx = i;
        if (hit_idx < 0)
            return STAT_NOT_FOUND;
        for (int i = hit_idx; i + 1 < key_total; i++)
            sorted_keys[i] = sorted_keys[i+1];
        key_total--;
        return STAT_OK;
    endfunction

    function automatic void predict_results(input logic [1:0] mode,
                                            input logic [KEY_BITS-1:0] key);
        case (mode)
            MODE_ADD: begin
                add_expected({{KEY_BITS{1'b0}}, insert_key(key), 1'b1});
            end
            MODE_REMOVE: begin
                add_expected({{KEY_BITS{1'b0}}, remove_key(key), 1'b1});
            end
            MODE_CLEAR: begin
                key_total = 0;
                add_expected({{KEY_BITS{1'b0}}, STAT_OK, 1'b1});
            end
            default: begin
                if (key_total == 0)
                    add_expected({{KEY_BITS{1'b0}}, STAT_EMPTY, 1'b1});
                else
                    for (int i = 0; i < key_total; i++)
                        add_expected({sorted_keys[i], STAT_OK,
                                      1'(i == key_total - 1)});
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            key_total = 0;
        end else begin
            // Compare before predicting: a result never belongs to an item taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result key_out %0d status %0d last %0d",
                             $time, i_key_out, i_status, i_last);
                    o_fail_count++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (i_key_out !== oldest_result.key_out) begin
                        $display("%0t: key_out expected %0d, got %0d",
                                 $time, oldest_result.key_out, i_key_out);
                        o_fail_count++;
                    end
                    if (i_status !== oldest_result.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, oldest_result.status, i_status);
                        o_fail_count++;
                    end
                    if (i_last !== oldest_result.last) begin
                        $display("%0t: last expected %0d, got %0d",
                                 $time, oldest_result.last, i_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_results(i_mode, i_key);
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- verif/sorted_key_set_store_test.sv -----
`timescale 1ns / 100ps

module sorted_key_set_store_test;
    import skss_pkg::*;

    localparam int KEY_MAX     = (1 << KEY_BITS) - 1;
    localparam int ITEM_TARGET = 400;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_mode;
    logic [KEY_BITS-1:0] i_key;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [KEY_BITS-1:0] o_key_out;
    logic [1:0]          o_status;
    logic                o_last;

    int                  store_fail_count;
    int                  store_pending;
    int                  items_sent;
    int                  burst_left;
    int                  cycle_count;
    bit                  hold_req;
    bit [KEY_BITS-1:0]   recent_keys [8];

    sorted_key_set_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_key_out   (o_key_out),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    skss_checker store_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_key_out    (o_key_out),
        .i_status     (o_status),
        .i_last       (o_last),
        .o_fail_count (store_fail_count),
        .o_pending    (store_pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: segments of random stall patterns, plus one long hold-off on request.
    initial begin
        int seg_kind;
        int seg_len;
        int phase;
        i_out_ready = 1'b0;
        phase = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            seg_kind = $urandom_range(0, 3);
            seg_len  = $urandom_range(10, 80);
            repeat (seg_len) begin
                case (seg_kind)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ((phase % 7) < 4);
                endcase
                phase++;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return KEY_BITS'($urandom_range(0, KEY_MAX));
            1: return KEY_BITS'($urandom_range(0, 3));
            2: return KEY_BITS'($urandom_range(KEY_MAX - 3, KEY_MAX));
            default: return recent_keys[3'($urandom_range(0, 7))];
        endcase
    endfunction

    // Offer one item and hold it until the transfer; idle between bursts.
    task automatic send_item(input logic [1:0] mode, input logic [KEY_BITS-1:0] key);
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_key      <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (mode == MODE_ADD)
            recent_keys[3'(items_sent % 8)] = key;
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic send_random(input int add_pct, input int remove_pct, input int emit_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            send_item(MODE_ADD, pick_key());
        else if (roll < add_pct + remove_pct)
            send_item(MODE_REMOVE, pick_key());
        else if (roll < add_pct + remove_pct + emit_pct)
            send_item(MODE_EMIT, KEY_BITS'($urandom_range(0, KEY_MAX)));
        else
            send_item(MODE_CLEAR, KEY_BITS'($urandom_range(0, KEY_MAX)));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (store_pending != 0);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_ADD;
        i_key       = '0;
        hold_req    = 1'b0;
        items_sent  = 0;
        burst_left  = $urandom_range(1, 8);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty store, duplicates, key extremes, hits and misses.
        send_item(MODE_EMIT,   7'd0);
        send_item(MODE_REMOVE, 7'd5);
        send_item(MODE_ADD,    KEY_BITS'(KEY_MAX));
        send_item(MODE_ADD,    7'd0);
        send_item(MODE_ADD,    7'd0);
        send_item(MODE_ADD,    7'd64);
        send_item(MODE_ADD,    KEY_BITS'(KEY_MAX));
        send_item(MODE_EMIT,   7'd0);
        send_item(MODE_REMOVE, 7'd0);
        send_item(MODE_REMOVE, KEY_BITS'(KEY_MAX));
        send_item(MODE_REMOVE, 7'd3);
        send_item(MODE_EMIT,   KEY_BITS'(KEY_MAX));
        send_item(MODE_CLEAR,  KEY_BITS'(KEY_MAX));
        send_item(MODE_EMIT,   7'd85);
        send_item(MODE_ADD,    7'd42);
        send_item(MODE_ADD,    7'd85);
        send_item(MODE_EMIT,   7'd0);
        send_item(MODE_REMOVE, 7'd85);
        send_item(MODE_CLEAR,  7'd0);
        send_item(MODE_ADD,    7'd1);
        send_item(MODE_EMIT,   7'd0);

        // Fill past capacity so the overflow drop and full emits are covered.
        send_item(MODE_CLEAR, 7'd0);
        repeat (CAPACITY + 2) send_item(MODE_ADD, KEY_BITS'($urandom_range(0, KEY_MAX)));
        send_item(MODE_EMIT, 7'd0);
        send_item(MODE_REMOVE, recent_keys[3'($urandom_range(0, 7))]);
        send_item(MODE_ADD, KEY_BITS'($urandom_range(0, KEY_MAX)));
        send_item(MODE_EMIT, 7'd0);

        wait_drained();
        hold_req = 1'b1;

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(30, 40)) send_random(85, 8, 7);
                send_item(MODE_EMIT, KEY_BITS'($urandom_range(0, KEY_MAX)));
                if ($urandom_range(0, 1) != 0)
                    send_item(MODE_CLEAR, KEY_BITS'($urandom_range(0, KEY_MAX)));
            end else begin
                repeat ($urandom_range(10, 30)) send_random(40, 30, 20);
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (store_fail_count == 0 && store_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
